FILE: sv/dual_background_pixel_update_assert.svh
// Assertion macros for the dual background pixel update block.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef DUAL_BACKGROUND_PIXEL_UPDATE_ASSERT_SVH
`define DUAL_BACKGROUND_PIXEL_UPDATE_ASSERT_SVH

// Condition in this cycle implies consequence in the next cycle.
`define DBPU_ASSERT_NEXT(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error("dbpu assertion failed");

// Condition implies consequence in the same cycle.
`define DBPU_ASSERT_NOW(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (conseq)) \
    else $error("dbpu assertion failed");

`endif

FILE: sv/dbpu_pkg.sv
// Shared types, constants and helpers for the dual background pixel update.
// No dependencies.
`default_nettype none

package dbpu_pkg;

  localparam int unsigned PixW = 8;
  localparam int unsigned QW   = 16;
  localparam int unsigned WW   = 31;  // Q1.30 weight, max 1.0 = 2^30

  localparam logic [QW-1:0] Q15_ONE  = 16'h8000;
  localparam logic [WW-1:0] Q30_HALF = 31'h2000_0000;

  typedef enum logic [1:0] {
    CASE_DARK  = 2'd0,
    CASE_LIGHT = 2'd1,
    CASE_BOTH  = 2'd2
  } update_case_e;

  typedef enum logic [0:0] {
    REG_LEARN_RATE      = 1'b0,
    REG_LEARN_RATE_BOTH = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic mul;  // product stage advances
    logic rnd;  // rounding stage advances
  } lane_en_t;

  // Clamp a Q1.15 value to 1.0.
  function automatic logic [QW-1:0] sat_q15(input logic [QW-1:0] v);
    return (v > Q15_ONE) ? Q15_ONE : v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/dbpu_lane.sv
// One channel blend: product stage then round and clamp stage.
// Depends on dbpu_pkg.
`default_nettype none

module dbpu_lane (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dbpu_pkg::lane_en_t         en_i,
  input  wire logic [dbpu_pkg::PixW-1:0]  bg_i,
  input  wire logic [dbpu_pkg::PixW-1:0]  src_i,
  input  wire logic [dbpu_pkg::WW-1:0]    w_i,
  output logic      [dbpu_pkg::PixW-1:0]  res_o
);
  import dbpu_pkg::*;

  logic signed [PixW:0]   diff;
  logic signed [WW:0]     w_s;
  logic signed [40:0]     prod_d, prod_q;
  logic        [PixW-1:0] bg_q;
  logic signed [40:0]     acc;
  logic        [PixW-1:0] res_d, res_q;

  // bg*(1-w) + src*w == bg + (src-bg)*w
  assign diff   = $signed({1'b0, src_i}) - $signed({1'b0, bg_i});
  assign w_s    = $signed({1'b0, w_i});
  assign prod_d = diff * w_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      bg_q   <= '0;
    end else if (en_i.mul) begin
      prod_q <= prod_d;
      bg_q   <= bg_i;
    end
  end

  assign acc   = $signed({3'b000, bg_q, 30'd0}) + prod_q + $signed({10'd0, Q30_HALF});
  assign res_d = (acc[40:38] != 3'd0) ? 8'hFF : acc[37:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (en_i.rnd) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: sv/dual_background_pixel_update.sv
// Top level of the dual background pixel update: case select, weight stage, six lanes.
// Depends on dbpu_pkg, dbpu_lane and dual_background_pixel_update_assert.svh.
//
//  channel  | signals                                 | direction
//  ---------+-----------------------------------------+----------
//  pixel in | in_valid_i / in_ready_o, src/light/dark | into block
//  result   | out_valid_o / out_ready_i, new_*, case  | out of block
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i         | into block
//
// Four register stages: sums and case select, weight multiply, channel products,
// round and clamp. One pixel per cycle is sustained while out_ready_i is high.
// Each stage advances when empty or when the stage after it advances, so bubbles
// fill and a stall at the output holds every transaction in place.
// Reset clears valid bits and both rate registers.
`default_nettype none

module dual_background_pixel_update (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  src_c0_i,
  input  wire logic [7:0]  src_c1_i,
  input  wire logic [7:0]  src_c2_i,
  input  wire logic [7:0]  light_c0_i,
  input  wire logic [7:0]  light_c1_i,
  input  wire logic [7:0]  light_c2_i,
  input  wire logic [7:0]  dark_c0_i,
  input  wire logic [7:0]  dark_c1_i,
  input  wire logic [7:0]  dark_c2_i,
  input  wire logic [15:0] fixed_weight_i,
  input  wire logic [15:0] hold_level_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       new_light_c0_o,
  output logic [7:0]       new_light_c1_o,
  output logic [7:0]       new_light_c2_o,
  output logic [7:0]       new_dark_c0_o,
  output logic [7:0]       new_dark_c1_o,
  output logic [7:0]       new_dark_c2_o,
  output logic [1:0]       update_case_o
);
  import dbpu_pkg::*;

  // Configuration
  logic [QW-1:0] learn_rate_q, learn_rate_both_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q      <= '0;
      learn_rate_both_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_LEARN_RATE:      learn_rate_q      <= cfg_data_i;
        REG_LEARN_RATE_BOTH: learn_rate_both_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage enables and valid bits
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign in_ready_o  = en1;
  assign out_valid_o = v4_q;

  // Stage 1: channel sums, case select, clamp Q1.15 inputs
  logic [PixW-1:0] src_in [3];
  logic [PixW-1:0] lt_in  [3];
  logic [PixW-1:0] dk_in  [3];
  logic [9:0]      ssum, lsum, dsum;
  update_case_e    case_d1;

  assign src_in[0] = src_c0_i;
  assign src_in[1] = src_c1_i;
  assign src_in[2] = src_c2_i;
  assign lt_in[0]  = light_c0_i;
  assign lt_in[1]  = light_c1_i;
  assign lt_in[2]  = light_c2_i;
  assign dk_in[0]  = dark_c0_i;
  assign dk_in[1]  = dark_c1_i;
  assign dk_in[2]  = dark_c2_i;

  assign ssum = 10'(src_c0_i) + 10'(src_c1_i) + 10'(src_c2_i);
  assign lsum = 10'(light_c0_i) + 10'(light_c1_i) + 10'(light_c2_i);
  assign dsum = 10'(dark_c0_i) + 10'(dark_c1_i) + 10'(dark_c2_i);

  always_comb begin
    if (ssum < dsum) begin
      case_d1 = CASE_DARK;
    end else if (ssum > lsum) begin
      case_d1 = CASE_LIGHT;
    end else begin
      case_d1 = CASE_BOTH;
    end
  end

  logic [PixW-1:0] src_q1 [3];
  logic [PixW-1:0] lt_q1  [3];
  logic [PixW-1:0] dk_q1  [3];
  logic [QW-1:0]   fw_q1, omh_q1;
  update_case_e    case_q1;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        src_q1[i] <= src_in[i];
        lt_q1[i]  <= lt_in[i];
        dk_q1[i]  <= dk_in[i];
      end
      fw_q1   <= sat_q15(fixed_weight_i);
      omh_q1  <= Q15_ONE - sat_q15(hold_level_i);
      case_q1 <= case_d1;
    end
  end

  // Stage 2: derive the weight, route it to the side that moves
  logic [WW-1:0] wmul;
  logic [WW-1:0] wprim, wboth, wl_d2, wd_d2;

  // Product is at most 2^30, so it fits the Q1.30 weight.
  assign wmul  = WW'(omh_q1) * WW'(sat_q15(learn_rate_q));
  assign wprim = (fw_q1 != '0) ? {fw_q1, 15'd0} : wmul;
  assign wboth = {sat_q15(learn_rate_both_q), 15'd0};

  // A zero weight passes the background through unchanged.
  always_comb begin
    case (case_q1)
      CASE_DARK: begin
        wl_d2 = '0;
        wd_d2 = wprim;
      end
      CASE_LIGHT: begin
        wl_d2 = wprim;
        wd_d2 = '0;
      end
      default: begin
        wl_d2 = wboth;
        wd_d2 = wboth;
      end
    endcase
  end

  logic [PixW-1:0] src_q2 [3];
  logic [PixW-1:0] lt_q2  [3];
  logic [PixW-1:0] dk_q2  [3];
  logic [WW-1:0]   wl_q2, wd_q2;
  update_case_e    case_q2, case_q3, case_q4;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        src_q2[i] <= src_q1[i];
        lt_q2[i]  <= lt_q1[i];
        dk_q2[i]  <= dk_q1[i];
      end
      wl_q2   <= wl_d2;
      wd_q2   <= wd_d2;
      case_q2 <= case_q1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) case_q3 <= case_q2;
    if (en4) case_q4 <= case_q3;
  end

  // Stages 3 and 4: per-channel product, then round and clamp
  lane_en_t        lane_en;
  logic [PixW-1:0] lt_res [3];
  logic [PixW-1:0] dk_res [3];

  assign lane_en.mul = en3;
  assign lane_en.rnd = en4;

  for (genvar g = 0; g < 3; g++) begin : g_ch
    dbpu_lane u_light (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (lane_en),
      .bg_i   (lt_q2[g]),
      .src_i  (src_q2[g]),
      .w_i    (wl_q2),
      .res_o  (lt_res[g])
    );
    dbpu_lane u_dark (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (lane_en),
      .bg_i   (dk_q2[g]),
      .src_i  (src_q2[g]),
      .w_i    (wd_q2),
      .res_o  (dk_res[g])
    );
  end

  assign new_light_c0_o = lt_res[0];
  assign new_light_c1_o = lt_res[1];
  assign new_light_c2_o = lt_res[2];
  assign new_dark_c0_o  = dk_res[0];
  assign new_dark_c1_o  = dk_res[1];
  assign new_dark_c2_o  = dk_res[2];
  assign update_case_o  = case_q4;

  // Checks
`include "dual_background_pixel_update_assert.svh"

  `DBPU_ASSERT_NEXT(a_accept_fills_s1, in_valid_i && in_ready_o, v1_q)
  `DBPU_ASSERT_NEXT(a_s2_stall_holds, v2_q && !en3, v2_q && $stable(wl_q2) && $stable(wd_q2))
  `DBPU_ASSERT_NOW(a_dark_keeps_light, v2_q && case_q2 == CASE_DARK, wl_q2 == '0)
  `DBPU_ASSERT_NOW(a_light_keeps_dark, v2_q && case_q2 == CASE_LIGHT, wd_q2 == '0)

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for dual_background_pixel_update: a directed stimulus table, then
// random pixels under several rate settings and idle patterns, checked against the table
// or a local predictor. Depends on dbpu_pkg and the dual_background_pixel_update RTL.
`default_nettype none

module tb_top;
  import dbpu_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned RandPerPhase  = 180;
  localparam int unsigned NumPhases     = 8;
  localparam logic [63:0] UnityQ30      = 64'd1 << 30;
  localparam logic [63:0] HalfQ30       = 64'd1 << 29;

  typedef struct packed {
    logic [0:2][7:0] src;
    logic [0:2][7:0] light;
    logic [0:2][7:0] dark;
    logic [15:0]     fw;
    logic [15:0]     hold;
  } pixel_t;

  typedef struct packed {
    logic [0:2][7:0] light;
    logic [0:2][7:0] dark;
    update_case_e    ucase;
  } bg_update_t;

  typedef struct {
    logic [15:0] rate;
    logic [15:0] rate_both;
    pixel_t      px;
    bit          typed;
    bg_update_t  res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_idx_i   = REG_LEARN_RATE;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  src_c0_i    = '0;
  logic [7:0]  src_c1_i    = '0;
  logic [7:0]  src_c2_i    = '0;
  logic [7:0]  light_c0_i  = '0;
  logic [7:0]  light_c1_i  = '0;
  logic [7:0]  light_c2_i  = '0;
  logic [7:0]  dark_c0_i   = '0;
  logic [7:0]  dark_c1_i   = '0;
  logic [7:0]  dark_c2_i   = '0;
  logic [15:0] fixed_weight_i = '0;
  logic [15:0] hold_level_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  new_light_c0_o;
  logic [7:0]  new_light_c1_o;
  logic [7:0]  new_light_c2_o;
  logic [7:0]  new_dark_c0_o;
  logic [7:0]  new_dark_c1_o;
  logic [7:0]  new_dark_c2_o;
  logic [1:0]  update_case_o;

  dual_background_pixel_update u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .src_c0_i       (src_c0_i),
    .src_c1_i       (src_c1_i),
    .src_c2_i       (src_c2_i),
    .light_c0_i     (light_c0_i),
    .light_c1_i     (light_c1_i),
    .light_c2_i     (light_c2_i),
    .dark_c0_i      (dark_c0_i),
    .dark_c1_i      (dark_c1_i),
    .dark_c2_i      (dark_c2_i),
    .fixed_weight_i (fixed_weight_i),
    .hold_level_i   (hold_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .new_light_c0_o (new_light_c0_o),
    .new_light_c1_o (new_light_c1_o),
    .new_light_c2_o (new_light_c2_o),
    .new_dark_c0_o  (new_dark_c0_o),
    .new_dark_c1_o  (new_dark_c1_o),
    .new_dark_c2_o  (new_dark_c2_o),
    .update_case_o  (update_case_o)
  );

  // Local copy of the rate registers, updated on every write.
  logic [15:0] cur_rate      = '0;
  logic [15:0] cur_rate_both = '0;

  bg_update_t  pending_updates[$];
  stim_row_t   directed_rows[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_pixels = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned n_settings = 0;
  int unsigned n_by_case[3] = '{0, 0, 0};
  int unsigned quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [15:0] clamp_unit(logic [15:0] v);
    return (v > Q15_ONE) ? Q15_ONE : v;
  endfunction

  // bg*(1-w) + s*w with w in Q1.30, rounded half up, clamped to 8 bits
  function automatic logic [7:0] blend_channel(logic [7:0] bg, logic [7:0] s, logic [30:0] w);
    logic [63:0] acc;
    acc = 64'(bg) * (UnityQ30 - 64'(w)) + 64'(s) * 64'(w) + HalfQ30;
    acc = acc >> 30;
    return (acc > 64'd255) ? 8'd255 : acc[7:0];
  endfunction

  function automatic bg_update_t blend_backgrounds(pixel_t p);
    bg_update_t  r;
    logic [9:0]  s_sum;
    logic [9:0]  l_sum;
    logic [9:0]  d_sum;
    logic [30:0] w;
    logic [30:0] w_both;
    s_sum = 10'(p.src[0]) + 10'(p.src[1]) + 10'(p.src[2]);
    l_sum = 10'(p.light[0]) + 10'(p.light[1]) + 10'(p.light[2]);
    d_sum = 10'(p.dark[0]) + 10'(p.dark[1]) + 10'(p.dark[2]);
    if (clamp_unit(p.fw) != 16'd0) begin
      w = {clamp_unit(p.fw), 15'd0};
    end else begin
      w = 31'((32'(Q15_ONE) - 32'(clamp_unit(p.hold))) * 32'(clamp_unit(cur_rate)));
    end
    w_both = {clamp_unit(cur_rate_both), 15'd0};
    r.light = p.light;
    r.dark  = p.dark;
    if (s_sum < d_sum) begin
      r.ucase = CASE_DARK;
      for (int c = 0; c < 3; c++) r.dark[c] = blend_channel(p.dark[c], p.src[c], w);
    end else if (s_sum > l_sum) begin
      r.ucase = CASE_LIGHT;
      for (int c = 0; c < 3; c++) r.light[c] = blend_channel(p.light[c], p.src[c], w);
    end else begin
      r.ucase = CASE_BOTH;
      for (int c = 0; c < 3; c++) begin
        r.light[c] = blend_channel(p.light[c], p.src[c], w_both);
        r.dark[c]  = blend_channel(p.dark[c], p.src[c], w_both);
      end
    end
    return r;
  endfunction

  function automatic void add_row(logic [15:0] rate, logic [15:0] rate_both,
                                  logic [23:0] src, logic [23:0] light, logic [23:0] dark,
                                  logic [15:0] fw, logic [15:0] hold, bit typed,
                                  logic [23:0] exp_light, logic [23:0] exp_dark,
                                  update_case_e exp_case);
    stim_row_t row;
    row.rate      = rate;
    row.rate_both = rate_both;
    row.px        = '{src: src, light: light, dark: dark, fw: fw, hold: hold};
    row.typed     = typed;
    row.res       = '{light: exp_light, dark: exp_dark, ucase: exp_case};
    directed_rows.push_back(row);
  endfunction

  function automatic logic [15:0] rand_q15();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return Q15_ONE;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(32'h8000, 32'hFFFF));
      4:       return 16'($urandom);
      default: return 16'($urandom_range(32'h8000));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int unsigned shape;
    shape   = $urandom_range(99);
    p.src   = 24'($urandom);
    p.light = 24'($urandom);
    p.dark  = 24'($urandom);
    // Land on the sum comparisons' boundaries and the channel extremes now and then.
    if (shape < 10) begin
      p.src = p.dark;
    end else if (shape < 20) begin
      p.src = p.light;
    end else if (shape < 26) begin
      p.src = {$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
               $urandom_range(1) ? 8'hFF : 8'h00};
    end
    p.fw   = ($urandom_range(99) < 45) ? 16'h0000 : rand_q15();
    p.hold = rand_q15();
    return p;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == REG_LEARN_RATE) cur_rate = value;
    else cur_rate_both = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_rates(logic [15:0] rate, logic [15:0] rate_both);
    write_reg(REG_LEARN_RATE, rate);
    write_reg(REG_LEARN_RATE_BOTH, rate_both);
    n_settings++;
  endtask

  // Drop valid and let the pipeline empty before any register write.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic drive_pixel(pixel_t p, bg_update_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    src_c0_i       <= p.src[0];
    src_c1_i       <= p.src[1];
    src_c2_i       <= p.src[2];
    light_c0_i     <= p.light[0];
    light_c1_i     <= p.light[1];
    light_c2_i     <= p.light[2];
    dark_c0_i      <= p.dark[0];
    dark_c1_i      <= p.dark[1];
    dark_c2_i      <= p.dark[2];
    fixed_weight_i <= p.fw;
    hold_level_i   <= p.hold;
    // Hold until the transaction is taken.
    do @(posedge clk_i); while (!in_ready_o);
    pending_updates.push_back(want);
    n_pixels++;
  endtask

  always @(posedge clk_i) begin : result_check
    bg_update_t got;
    bg_update_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.light = {new_light_c0_o, new_light_c1_o, new_light_c2_o};
      got.dark  = {new_dark_c0_o, new_dark_c1_o, new_dark_c2_o};
      got.ucase = update_case_e'(update_case_o);
      n_results++;
      if (pending_updates.size() == 0) begin
        $error("result transaction with no pending pixel");
        n_errors++;
      end else begin
        want = pending_updates.pop_front();
        if (want.ucase <= CASE_BOTH) n_by_case[want.ucase]++;
        for (int c = 0; c < 3; c++) begin
          check_field($sformatf("new_light_c%0d", c), want.light[c], got.light[c]);
          check_field($sformatf("new_dark_c%0d", c), want.dark[c], got.dark[c]);
        end
        check_field("update_case", want.ucase, got.ucase);
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("no transaction for %0d cycles, %0d results pending", quiet_cycles,
               pending_updates.size());
      $display("dual_background_pixel_update test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] phase_rate[NumPhases];
    logic [15:0] phase_rate_both[NumPhases];
    pixel_t      p;

    // Rates at reset (zero): untouched backgrounds are easy to read off.
    add_row(16'h0000, 16'h0000, 24'h000000, 24'h000000, 24'h000000, 16'h0000, 16'h0000,
            1, 24'h000000, 24'h000000, CASE_BOTH);
    add_row(16'h0000, 16'h0000, 24'hFFFFFF, 24'h000000, 24'h000000, 16'h8000, 16'h0000,
            1, 24'hFFFFFF, 24'h000000, CASE_LIGHT);
    add_row(16'h0000, 16'h0000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'h0000,
            1, 24'hFFFFFF, 24'h000000, CASE_DARK);
    add_row(16'h0000, 16'h0000, 24'h102030, 24'h405060, 24'h708090, 16'h0000, 16'h0000,
            1, 24'h405060, 24'h708090, CASE_DARK);
    add_row(16'h0000, 16'h0000, 24'hC0C0C0, 24'h404040, 24'h101010, 16'h4000, 16'h0000,
            0, '0, '0, CASE_DARK);
    add_row(16'h0000, 16'h0000, 24'h010203, 24'hFEFDFC, 24'h808080, 16'h0001, 16'h1234,
            0, '0, '0, CASE_DARK);
    // dark background brighter than the light one
    add_row(16'h0000, 16'h0000, 24'h808080, 24'h202020, 24'hE0E0E0, 16'h8000, 16'h0000,
            0, '0, '0, CASE_DARK);
    // source sum equal to the dark sum, channels differ
    add_row(16'h0000, 16'h0000, 24'h300000, 24'h050505, 24'h101010, 16'h2000, 16'h0000,
            0, '0, '0, CASE_DARK);
    // source sum equal to the light sum
    add_row(16'h0000, 16'h0000, 24'h0000FF, 24'h555555, 24'h000000, 16'h0000, 16'h0000,
            1, 24'h555555, 24'h000000, CASE_BOTH);
    add_row(16'h0000, 16'h0000, 24'hFF8000, 24'h102030, 24'h000000, 16'h8001, 16'h0000,
            0, '0, '0, CASE_DARK);
    add_row(16'h0000, 16'h0000, 24'h000000, 24'h111111, 24'h222222, 16'h0000, 16'hFFFF,
            1, 24'h111111, 24'h222222, CASE_DARK);
    // Full primary rate, both-rate above one: primary weight derived from the hold level.
    add_row(16'h8000, 16'hFFFF, 24'h123456, 24'hFFFFFF, 24'h000000, 16'h0000, 16'h0000,
            1, 24'h123456, 24'h123456, CASE_BOTH);
    add_row(16'h8000, 16'hFFFF, 24'h000000, 24'hFFFFFF, 24'h404040, 16'h0000, 16'h0000,
            1, 24'hFFFFFF, 24'h000000, CASE_DARK);
    add_row(16'h8000, 16'hFFFF, 24'hFFFFFF, 24'h404040, 24'h000000, 16'h0000, 16'h8000,
            1, 24'h404040, 24'h000000, CASE_LIGHT);
    add_row(16'h8000, 16'hFFFF, 24'hFFFFFF, 24'h404040, 24'h000000, 16'h0000, 16'hFFFF,
            1, 24'h404040, 24'h000000, CASE_LIGHT);
    add_row(16'h8000, 16'hFFFF, 24'h202020, 24'hFFFFFF, 24'h808080, 16'h0000, 16'h4000,
            0, '0, '0, CASE_DARK);
    add_row(16'h8000, 16'hFFFF, 24'hF0F0F0, 24'h101010, 24'h000000, 16'h0000, 16'h0001,
            0, '0, '0, CASE_DARK);
    add_row(16'hFFFF, 16'h8001, 24'h7F7F7F, 24'hFFFFFF, 24'h000000, 16'h0000, 16'h0000,
            0, '0, '0, CASE_DARK);
    add_row(16'hFFFF, 16'h8001, 24'h000000, 24'h808080, 24'h808080, 16'h0000, 16'h0000,
            0, '0, '0, CASE_DARK);
    add_row(16'h1234, 16'h0001, 24'hFF00FF, 24'hFFFFFF, 24'h000000, 16'h0000, 16'h0000,
            0, '0, '0, CASE_DARK);
    add_row(16'h1234, 16'h0001, 24'h030303, 24'h909090, 24'h505050, 16'h0000, 16'h2000,
            0, '0, '0, CASE_DARK);
    add_row(16'h1234, 16'h0001, 24'hE0E0E0, 24'h808080, 24'h000000, 16'h7FFF, 16'h8000,
            0, '0, '0, CASE_DARK);

    phase_rate      = '{16'h0000, 16'hFFFF, 16'h8000, 16'($urandom), 16'h8000, 16'h0001,
                        16'($urandom_range(32'h8000)), 16'($urandom_range(32'h8000))};
    phase_rate_both = '{16'h0000, 16'hFFFF, 16'h8000, 16'($urandom), 16'h0000, 16'h7FFF,
                        16'($urandom_range(32'h8000)), 16'($urandom)};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();

    foreach (directed_rows[i]) begin
      if (directed_rows[i].rate != cur_rate || directed_rows[i].rate_both != cur_rate_both) begin
        drain();
        set_rates(directed_rows[i].rate, directed_rows[i].rate_both);
      end
      drive_pixel(directed_rows[i].px, directed_rows[i].typed ? directed_rows[i].res
                                                              : blend_backgrounds(directed_rows[i].px));
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      set_rates(phase_rate[ph], phase_rate_both[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        p = random_pixel();
        drive_pixel(p, blend_backgrounds(p));
      end
    end

    drain();
    $display("%0d pixels sent, %0d results checked: %0d darker, %0d brighter, %0d between",
             n_pixels, n_results, n_by_case[0], n_by_case[1], n_by_case[2]);
    $display("%0d rate settings applied, zero and saturated rates among them", n_settings);
    if (n_errors == 0) begin
      $display("dual_background_pixel_update test passed");
    end else begin
      $display("dual_background_pixel_update test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+sv
sv/dbpu_pkg.sv
sv/dbpu_lane.sv
sv/dual_background_pixel_update.sv
tb/tb_top.sv
